// ----- rtl/svsam_pkg.sv -----
// Package for the sparse vector scale-add merge block.
// Holds the shared widths, register indexes, command types and arithmetic helpers.
// No dependencies.
`timescale 1ns / 1ps

package svsam_pkg;

  // Operand queue geometry
  localparam int QUEUE_DEPTH = 32;
  localparam int INDEX_BITS  = 32;
  localparam int VAL_W       = 32;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRY_W     = INDEX_BITS + VAL_W;

  // Stream payload widths: index in the low word, value in the high word
  localparam int FIELD_W = 32;
  localparam int DATA_W  = 2 * FIELD_W;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_A = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_B = 1'b1;
  localparam logic signed [VAL_W-1:0] SCALE_RESET = 32'sh0001_0000;

  // Arithmetic widths: exact product, rounded Q16.16 product, sum of two
  localparam int PROD_W = 2 * VAL_W;
  localparam int RND_W  = PROD_W - 16;
  localparam int ACC_W  = RND_W + 1;
  localparam logic signed [PROD_W-1:0] ROUND_HALF = 64'sd32768;

  typedef enum logic {
    OP_PUSH  = 1'b0,
    OP_CLOSE = 1'b1
  } cmd_op_e;

  // One classified input item on its way from the front to the back
  typedef struct packed {
    cmd_op_e                 op;
    logic                    op_b;
    logic [INDEX_BITS-1:0]   idx;
    logic signed [VAL_W-1:0] val;
  } cmd_t;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Round half up to Q16.16: floor((p + 2^15) / 2^16)
  function automatic logic signed [RND_W-1:0] round_q16(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] s;
    s = p + ROUND_HALF;
    return s[PROD_W-1:16];
  endfunction

  // Clamp to the signed 32-bit range
  function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [ACC_W-1:0] a);
    logic ovf_hi;
    logic ovf_lo;
    ovf_hi = !a[ACC_W-1] && (|a[ACC_W-1:VAL_W-1]);
    ovf_lo = a[ACC_W-1] && !(&a[ACC_W-1:VAL_W-1]);
    if (ovf_hi) begin
      return {1'b0, {(VAL_W-1){1'b1}}};
    end else if (ovf_lo) begin
      return {1'b1, {(VAL_W-1){1'b0}}};
    end
    return a[VAL_W-1:0];
  endfunction

endpackage

// ----- rtl/sparse_vector_scale_add_merge.sv -----
// Top level of the sparse vector scale-add merge block.
// Instantiates svsam_front and svsam_back; uses svsam_pkg.
`timescale 1ns / 1ps

// Usage
//   Computes scale_a * A + scale_b * B over two sparse vectors given as
//   (index, value) elements in rising index order.
//   s_axis: one element per transfer. tuser picks the operand (0 = A, 1 = B),
//   tlast closes that operand (no element then). tdata carries the index in
//   bits 31:0 and the Q16.16 value in bits 63:32.
//   m_axis: one merged element per transfer, index in 31:0, saturated value
//   in 63:32. tlast flags the end marker that follows once both operands
//   are closed and drained; tuser flags an element refused at a full or
//   closed queue (index echoed, value zero).
//   cfg: write scale_a (index 0) and scale_b (index 1) while idle.
// Sequence
//   Inputs land in a two-entry command queue and are applied one at a time.
//   A push or close passes IDLE, FETCH and DECIDE; a refused element goes
//   from IDLE straight to the emit step. Each released element passes
//   DECIDE, multiply, round and emit, with a second round step for equal
//   indices that go through the shared multiplier twice.
// Reset and stall
//   Reset empties both queues, clears the closed flags and loads both scales
//   with 1.0. A stalled receiver holds the output register; the merge waits
//   at its emit step while up to two further inputs are still taken.

module sparse_vector_scale_add_merge (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration write port
  input  logic                             cfg_we_i,
  input  logic [svsam_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [svsam_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // Input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [svsam_pkg::DATA_W-1:0]     s_axis_tdata,  // elem_index, elem_value
  input  logic                             s_axis_tlast,  // closes
  input  logic                             s_axis_tuser,  // kind
  // Output stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [svsam_pkg::DATA_W-1:0]     m_axis_tdata,  // out_index, out_value
  output logic                             m_axis_tlast,  // is_end
  output logic                             m_axis_tuser   // dropped
);

  svsam_pkg::cmd_t                cmd;
  logic                           cmd_valid;
  logic                           cmd_pop;
  logic [svsam_pkg::FIELD_W-1:0]  out_index;
  logic [svsam_pkg::VAL_W-1:0]    out_value;

  // Accept and classify input transfers
  svsam_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_o  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tlast_i   (s_axis_tlast),
    .s_tuser_i   (s_axis_tuser),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // Queue, merge, scale and emit
  svsam_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_index_o (out_index),
    .out_value_o (out_value),
    .out_end_o   (m_axis_tlast),
    .out_drop_o  (m_axis_tuser)
  );

  // Pack index low, value high
  assign m_axis_tdata = {out_value, out_index};

endmodule

// ----- rtl/svsam_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Used for the operand queues of the merge back end. No dependencies.
`timescale 1ns / 1ps

module svsam_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/svsam_front.sv -----
// Front end: accepts input transfers, classifies them into push or close
// commands and holds them in a two-entry command queue. Uses svsam_pkg.
`timescale 1ns / 1ps

module svsam_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_tvalid_i,
  output logic                      s_tready_o,
  input  logic [svsam_pkg::DATA_W-1:0] s_tdata_i,
  input  logic                      s_tlast_i,
  input  logic                      s_tuser_i,
  output logic                      cmd_valid_o,
  output svsam_pkg::cmd_t           cmd_o,
  input  logic                      cmd_pop_i
);

  svsam_pkg::cmd_t entry_q [2];
  logic            wr_ptr_q;
  logic            rd_ptr_q;
  logic [1:0]      fill_q;
  svsam_pkg::cmd_t cmd_in;
  logic            push;
  logic            pop;

  // Classify: tlast marks a close, tuser picks the operand; mask the index
  always_comb begin
    cmd_in.op   = s_tlast_i ? svsam_pkg::OP_CLOSE : svsam_pkg::OP_PUSH;
    cmd_in.op_b = s_tuser_i;
    cmd_in.idx  = s_tdata_i[svsam_pkg::INDEX_BITS-1:0];
    cmd_in.val  = s_tdata_i[svsam_pkg::DATA_W-1:svsam_pkg::FIELD_W];
  end

  assign s_tready_o  = (fill_q != 2'd2);
  assign cmd_valid_o = (fill_q != 2'd0);
  assign cmd_o       = entry_q[rd_ptr_q];
  assign push        = s_tvalid_i && s_tready_o;
  assign pop         = cmd_pop_i && cmd_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push) begin
        entry_q[wr_ptr_q] <= cmd_in;
        wr_ptr_q          <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !pop) begin
        fill_q <= fill_q + 2'd1;
      end else if (pop && !push) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end

endmodule

// ----- rtl/svsam_back.sv -----
// Back end: operand queues, merge sequencer, shared multiplier and output register.
// Uses svsam_pkg and two svsam_ram instances.
`timescale 1ns / 1ps

module svsam_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [svsam_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [svsam_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                          cmd_valid_i,
  input  svsam_pkg::cmd_t               cmd_i,
  output logic                          cmd_pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [svsam_pkg::FIELD_W-1:0] out_index_o,
  output logic [svsam_pkg::VAL_W-1:0]   out_value_o,
  output logic                          out_end_o,
  output logic                          out_drop_o
);

  localparam int IW = svsam_pkg::INDEX_BITS;
  localparam int VW = svsam_pkg::VAL_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_DECIDE,
    ST_MUL0,
    ST_RND0,
    ST_RND1,
    ST_EMIT
  } state_e;

  typedef enum logic [2:0] {
    DEC_A,
    DEC_B,
    DEC_AB,
    DEC_END,
    DEC_STOP
  } dec_e;

  state_e state_q;

  logic signed [VW-1:0] scale_a_q, scale_b_q;

  logic [svsam_pkg::PTR_W-1:0] head_a_q, tail_a_q, head_b_q, tail_b_q;
  logic [svsam_pkg::CNT_W-1:0] cnt_a_q, cnt_b_q;
  logic                        closed_a_q, closed_b_q;

  logic [svsam_pkg::ENTRY_W-1:0] rd_a, rd_b;
  logic                          we_a, we_b;
  logic [svsam_pkg::ENTRY_W-1:0] wdata;

  logic signed [VW-1:0]                   op0_val_q, op1_val_q;
  logic                                   op0_b_q, two_q, ret_idle_q;
  logic [IW-1:0]                          res_idx_q;
  logic                                   res_end_q, res_drop_q;
  logic signed [svsam_pkg::PROD_W-1:0]    prod_q;
  logic signed [svsam_pkg::RND_W-1:0]     rnd0_q, rnd1_q;

  logic                        out_valid_q, out_end_q, out_drop_q;
  logic [IW-1:0]               out_idx_q;
  logic signed [VW-1:0]        out_val_q;

  logic full_a, full_b, push_ok_a, push_ok_b, take_cmd, is_push;
  logic ha, hb;
  logic [IW-1:0] ia, ib;
  logic signed [VW-1:0] va, vb;
  dec_e dec;
  logic signed [VW-1:0] mul_x, mul_s;
  logic signed [svsam_pkg::PROD_W-1:0] product;
  logic signed [svsam_pkg::ACC_W-1:0] acc;
  logic emit_go;

  // Operand queues; read address follows the head pointer
  svsam_ram #(.WIDTH(svsam_pkg::ENTRY_W), .DEPTH(svsam_pkg::QUEUE_DEPTH)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (tail_a_q),
    .wdata_i (wdata),
    .raddr_i (head_a_q),
    .rdata_o (rd_a)
  );

  svsam_ram #(.WIDTH(svsam_pkg::ENTRY_W), .DEPTH(svsam_pkg::QUEUE_DEPTH)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (tail_b_q),
    .wdata_i (wdata),
    .raddr_i (head_b_q),
    .rdata_o (rd_b)
  );

  // Command intake: push to an open queue with room, otherwise drop
  assign full_a    = (cnt_a_q == svsam_pkg::CNT_W'(svsam_pkg::QUEUE_DEPTH));
  assign full_b    = (cnt_b_q == svsam_pkg::CNT_W'(svsam_pkg::QUEUE_DEPTH));
  assign take_cmd  = (state_q == ST_IDLE) && cmd_valid_i;
  assign is_push   = (cmd_i.op == svsam_pkg::OP_PUSH);
  assign push_ok_a = !cmd_i.op_b && !closed_a_q && !full_a;
  assign push_ok_b = cmd_i.op_b && !closed_b_q && !full_b;
  assign we_a      = take_cmd && is_push && push_ok_a;
  assign we_b      = take_cmd && is_push && push_ok_b;
  assign wdata     = {cmd_i.idx, cmd_i.val};
  assign cmd_pop_o = take_cmd;

  // Head compare
  always_comb begin
    ha  = (cnt_a_q != '0);
    hb  = (cnt_b_q != '0);
    ia  = rd_a[svsam_pkg::ENTRY_W-1:VW];
    ib  = rd_b[svsam_pkg::ENTRY_W-1:VW];
    va  = rd_a[VW-1:0];
    vb  = rd_b[VW-1:0];
    dec = DEC_STOP;
    if (ha && hb) begin
      if (ia < ib) begin
        dec = DEC_A;
      end else if (ib < ia) begin
        dec = DEC_B;
      end else begin
        dec = DEC_AB;
      end
    end else if (ha && closed_b_q) begin
      dec = DEC_A;
    end else if (hb && closed_a_q) begin
      dec = DEC_B;
    end else if (!ha && !hb && closed_a_q && closed_b_q) begin
      dec = DEC_END;
    end
  end

  // One shared multiplier: first operand in MUL0, second (always B) in RND0
  assign mul_x   = (state_q == ST_RND0) ? op1_val_q : op0_val_q;
  assign mul_s   = ((state_q == ST_RND0) || op0_b_q) ? scale_b_q : scale_a_q;
  assign product = mul_x * mul_s;

  assign acc     = {rnd0_q[svsam_pkg::RND_W-1], rnd0_q} + {rnd1_q[svsam_pkg::RND_W-1], rnd1_q};
  assign emit_go = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      scale_a_q   <= svsam_pkg::SCALE_RESET;
      scale_b_q   <= svsam_pkg::SCALE_RESET;
      head_a_q    <= '0;
      tail_a_q    <= '0;
      head_b_q    <= '0;
      tail_b_q    <= '0;
      cnt_a_q     <= '0;
      cnt_b_q     <= '0;
      closed_a_q  <= 1'b0;
      closed_b_q  <= 1'b0;
      op0_val_q   <= '0;
      op1_val_q   <= '0;
      op0_b_q     <= 1'b0;
      two_q       <= 1'b0;
      ret_idle_q  <= 1'b0;
      res_idx_q   <= '0;
      res_end_q   <= 1'b0;
      res_drop_q  <= 1'b0;
      prod_q      <= '0;
      rnd0_q      <= '0;
      rnd1_q      <= '0;
      out_valid_q <= 1'b0;
      out_idx_q   <= '0;
      out_val_q   <= '0;
      out_end_q   <= 1'b0;
      out_drop_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          svsam_pkg::REG_SCALE_A: scale_a_q <= cfg_data_i;
          svsam_pkg::REG_SCALE_B: scale_b_q <= cfg_data_i;
          default: ;
        endcase
      end

      // Release the output register on a transfer; the emit step reloads it
      if (out_ready_i && (state_q != ST_EMIT)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i) begin
            if (!is_push) begin
              if (cmd_i.op_b) begin
                closed_b_q <= 1'b1;
              end else begin
                closed_a_q <= 1'b1;
              end
              state_q <= ST_FETCH;
            end else if (push_ok_a) begin
              tail_a_q <= svsam_pkg::ptr_next(tail_a_q);
              cnt_a_q  <= cnt_a_q + 1'b1;
              state_q  <= ST_FETCH;
            end else if (push_ok_b) begin
              tail_b_q <= svsam_pkg::ptr_next(tail_b_q);
              cnt_b_q  <= cnt_b_q + 1'b1;
              state_q  <= ST_FETCH;
            end else begin
              // Refused element: report it and skip the merge
              res_idx_q  <= cmd_i.idx;
              rnd0_q     <= '0;
              rnd1_q     <= '0;
              res_end_q  <= 1'b0;
              res_drop_q <= 1'b1;
              ret_idle_q <= 1'b1;
              state_q    <= ST_EMIT;
            end
          end
        end

        ST_FETCH: begin
          state_q <= ST_DECIDE;
        end

        ST_DECIDE: begin
          res_end_q  <= 1'b0;
          res_drop_q <= 1'b0;
          ret_idle_q <= 1'b0;
          two_q      <= 1'b0;
          case (dec)
            DEC_A: begin
              head_a_q  <= svsam_pkg::ptr_next(head_a_q);
              cnt_a_q   <= cnt_a_q - 1'b1;
              res_idx_q <= ia;
              op0_val_q <= va;
              op0_b_q   <= 1'b0;
              state_q   <= ST_MUL0;
            end
            DEC_B: begin
              head_b_q  <= svsam_pkg::ptr_next(head_b_q);
              cnt_b_q   <= cnt_b_q - 1'b1;
              res_idx_q <= ib;
              op0_val_q <= vb;
              op0_b_q   <= 1'b1;
              state_q   <= ST_MUL0;
            end
            DEC_AB: begin
              head_a_q  <= svsam_pkg::ptr_next(head_a_q);
              cnt_a_q   <= cnt_a_q - 1'b1;
              head_b_q  <= svsam_pkg::ptr_next(head_b_q);
              cnt_b_q   <= cnt_b_q - 1'b1;
              res_idx_q <= ia;
              op0_val_q <= va;
              op1_val_q <= vb;
              op0_b_q   <= 1'b0;
              two_q     <= 1'b1;
              state_q   <= ST_MUL0;
            end
            DEC_END: begin
              // Both operands done: reopen for the next pair of vectors
              closed_a_q <= 1'b0;
              closed_b_q <= 1'b0;
              res_idx_q  <= '0;
              rnd0_q     <= '0;
              rnd1_q     <= '0;
              res_end_q  <= 1'b1;
              ret_idle_q <= 1'b1;
              state_q    <= ST_EMIT;
            end
            default: begin
              state_q <= ST_IDLE;
            end
          endcase
        end

        ST_MUL0: begin
          prod_q  <= product;
          state_q <= ST_RND0;
        end

        ST_RND0: begin
          rnd0_q <= svsam_pkg::round_q16(prod_q);
          if (two_q) begin
            prod_q  <= product;
            state_q <= ST_RND1;
          end else begin
            rnd1_q  <= '0;
            state_q <= ST_EMIT;
          end
        end

        ST_RND1: begin
          rnd1_q  <= svsam_pkg::round_q16(prod_q);
          state_q <= ST_EMIT;
        end

        ST_EMIT: begin
          // Hold the result until the output register is free
          if (emit_go) begin
            out_valid_q <= 1'b1;
            out_idx_q   <= res_idx_q;
            out_val_q   <= svsam_pkg::sat_val(acc);
            out_end_q   <= res_end_q;
            out_drop_q  <= res_drop_q;
            state_q     <= ret_idle_q ? ST_IDLE : ST_DECIDE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_index_o = svsam_pkg::FIELD_W'(out_idx_q);
  assign out_value_o = out_val_q;
  assign out_end_o   = out_end_q;
  assign out_drop_o  = out_drop_q;

  // Queue fill never passes the depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_a_q <= svsam_pkg::CNT_W'(svsam_pkg::QUEUE_DEPTH)) &&
    (cnt_b_q <= svsam_pkg::CNT_W'(svsam_pkg::QUEUE_DEPTH)))
    else $error("operand queue count out of range");

  // No write lands in a full queue
  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(we_a && full_a) && !(we_b && full_b))
    else $error("write into full operand queue");

  // An end marker leaves both queues empty
  a_end_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && res_end_q && emit_go) |-> (cnt_a_q == '0 && cnt_b_q == '0))
    else $error("end marker with queued elements");

  // A refused element carries a zero value and is no end marker
  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_drop_q) |-> (out_val_q == '0 && !out_end_q))
    else $error("dropped result with nonzero value");

  // A command is only taken while no merge is in flight
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |=> (state_q == ST_FETCH || state_q == ST_EMIT))
    else $error("command taken outside idle");

endmodule
